### rtl/core/plane_crossing_termination_core_assert.svh
// ----------------------------------------------------------------------------
// plane crossing termination core assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef PLANE_CROSSING_TERMINATION_CORE_ASSERT_SVH
`define PLANE_CROSSING_TERMINATION_CORE_ASSERT_SVH

// consequent checked in the same cycle
`define PCT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define PCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pct_pkg.sv
// ----------------------------------------------------------------------------
// pct_pkg
// shared widths, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package pct_pkg;

    localparam int CFG_DW  = 48;
    localparam int CFG_IW  = 3;
    localparam int DW      = 52;
    localparam int MA_W    = 17;
    localparam int MB_W    = 33;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int TPROD_W = 66;
    localparam int CNT_W   = 5;

    localparam logic [CNT_W-1:0] CNT_LAST  = 5'd31;
    localparam logic [CNT_W-1:0] MUL_LAST  = 5'd6;
    localparam logic [CNT_W-1:0] MUL_SWAP  = 5'd4;
    localparam logic [CNT_W-1:0] TMUL_LAST = 5'd2;

    localparam logic [CFG_IW-1:0] CFG_PLANE_NORMAL  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_PLANE_OFFSET  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_MAX_CROSSINGS = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_PERIOD        = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_TOLERANCE     = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_TIME_MODE     = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_TIME_LIMIT    = 3'd6;
    localparam logic [CFG_IW-1:0] CFG_MAX_STEPS     = 3'd7;

    localparam logic [1:0] TM_FWD = 2'd1;
    localparam logic [1:0] TM_BWD = 2'd2;

    localparam logic [1:0] RSN_NONE  = 2'd0;
    localparam logic [1:0] RSN_CROSS = 2'd1;
    localparam logic [1:0] RSN_TIME  = 2'd2;
    localparam logic [1:0] RSN_STEPS = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_TEST,
        S_DIV,
        S_TMUL,
        S_TIME,
        S_MOD,
        S_FILT,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        MS_SX,
        MS_SY,
        MS_SZ,
        MS_EX,
        MS_EY,
        MS_EZ,
        MS_QLO,
        MS_QHI,
        MS_TOL
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SWAP
    } acc_op_t;

    typedef enum logic [2:0] {
        DIV_HOLD,
        DIV_INIT_Q,
        DIV_INIT_M,
        DIV_STEP_NS,
        DIV_STEP
    } div_op_t;

    typedef enum logic [1:0] {
        TP_HOLD,
        TP_LO,
        TP_HI
    } tp_op_t;

    typedef struct packed {
        logic     in_load;
        logic     mul_en;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     cross_load;
        logic     cross_filt;
        div_op_t  div_op;
        tp_op_t   tp_op;
        logic     out_load;
    } pct_cmd_t;

    typedef struct packed {
        logic cand;
        logic period_on;
    } pct_status_t;

endpackage

### rtl/core/plane_crossing_termination_core.sv
// ----------------------------------------------------------------------------
// plane_crossing_termination_core
// positive-direction plane crossing detector with period filter, saturating
// crossing and step counters and termination reporting
// ----------------------------------------------------------------------------
// sequencing: a word is accepted only in idle and none is taken until the
//   result is handed off and the controller is back in idle; the shared
//   shift-subtract unit runs 32 steps for the interpolation divide and 32 for
//   the modulo, only for a candidate crossing with the period filter on
// reset: asynchronous, clears config registers, counters and the result valid
// ----------------------------------------------------------------------------
module plane_crossing_termination_core
    import pct_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IW-1:0]    cfg_index,
    input  logic [CFG_DW-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [31:0]   start_x,
    input  logic signed [31:0]   start_y,
    input  logic signed [31:0]   start_z,
    input  logic signed [31:0]   end_x,
    input  logic signed [31:0]   end_y,
    input  logic signed [31:0]   end_z,
    input  logic signed [31:0]   start_time,
    input  logic signed [31:0]   end_time,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 crossed,
    output logic                 terminate,
    output logic [1:0]           stop_reason,
    output logic [15:0]          crossing_total
);

    pct_cmd_t    cmd;
    pct_status_t status;

    pct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    pct_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .start_x        (start_x),
        .start_y        (start_y),
        .start_z        (start_z),
        .end_x          (end_x),
        .end_y          (end_y),
        .end_z          (end_z),
        .start_time     (start_time),
        .end_time       (end_time),
        .cmd            (cmd),
        .status         (status),
        .crossed        (crossed),
        .terminate      (terminate),
        .stop_reason    (stop_reason),
        .crossing_total (crossing_total)
    );

endmodule

### rtl/core/pct_datapath.sv
// ----------------------------------------------------------------------------
// pct_datapath
// config registers, shared multiplier, distance accumulator, shift-subtract
// divider, period filter, counters and result register
// ----------------------------------------------------------------------------
module pct_datapath
    import pct_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IW-1:0]        cfg_index,
    input  logic [CFG_DW-1:0]        cfg_data,
    input  logic signed [31:0]       start_x,
    input  logic signed [31:0]       start_y,
    input  logic signed [31:0]       start_z,
    input  logic signed [31:0]       end_x,
    input  logic signed [31:0]       end_y,
    input  logic signed [31:0]       end_z,
    input  logic signed [31:0]       start_time,
    input  logic signed [31:0]       end_time,
    input  pct_cmd_t                 cmd,
    output pct_status_t              status,
    output logic                     crossed,
    output logic                     terminate,
    output logic [1:0]               stop_reason,
    output logic [15:0]              crossing_total
);

    // configuration
    logic [47:0]        normal_reg;
    logic [30:0]        offset_reg;
    logic [15:0]        max_cross_reg;
    logic [30:0]        period_reg;
    logic [15:0]        tol_reg;
    logic [1:0]         tmode_reg;
    logic signed [31:0] tlimit_reg;
    logic [31:0]        max_steps_reg;

    // word registers
    logic signed [31:0] sx_reg, sy_reg, sz_reg, ex_reg, ey_reg, ez_reg;
    logic signed [31:0] t0_reg, t1_reg;

    // arithmetic
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [DW-1:0]      acc_reg;
    logic signed [DW-1:0]      d0_reg;
    logic [DW-1:0]             rem_reg;
    logic [31:0]               quo_reg;
    logic [DW-1:0]             dvs_reg;
    logic signed [TPROD_W-1:0] tprod_reg;
    logic                      cross_reg;

    // counters
    logic [15:0] cc_reg;
    logic [31:0] sc_reg;

    // result
    logic        crossed_reg;
    logic        term_reg;
    logic [1:0]  reason_reg;
    logic [15:0] total_reg;

    logic signed [15:0]        n0, n1, n2;
    logic signed [MB_W-1:0]    dt;
    logic signed [MA_W-1:0]    ma;
    logic signed [MB_W-1:0]    mb;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [DW-1:0]      off14;
    logic signed [DW-1:0]      prod_ext;
    logic signed [DW-1:0]      dot;
    logic [DW-1:0]             div_t;
    logic [DW:0]               div_diff;
    logic                      div_ge;
    logic signed [TPROD_W-1:0] prod_t;
    logic signed [34:0]        tm;
    logic signed [34:0]        tm_neg;
    logic [31:0]               abs_tm;
    logic [46:0]               r16;
    logic [46:0]               tp;
    logic [46:0]               per16;
    logic [46:0]               hi_bound;
    logic                      keep;
    logic                      period_on;
    logic [15:0]               cc_new;
    logic                      hit_cross;
    logic                      hit_time;
    logic                      hit_steps;
    logic                      term_next;
    logic [1:0]                reason_next;

    assign n0 = normal_reg[15:0];
    assign n1 = normal_reg[31:16];
    assign n2 = normal_reg[47:32];
    assign dt = {t1_reg[31], t1_reg} - {t0_reg[31], t0_reg};

    assign period_on        = (period_reg != '0);
    assign status.period_on = period_on;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg    <= '0;
            offset_reg    <= '0;
            max_cross_reg <= '0;
            period_reg    <= '0;
            tol_reg       <= '0;
            tmode_reg     <= '0;
            tlimit_reg    <= '0;
            max_steps_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PLANE_NORMAL:  normal_reg    <= cfg_data[47:0];
                CFG_PLANE_OFFSET:  offset_reg    <= cfg_data[30:0];
                CFG_MAX_CROSSINGS: max_cross_reg <= cfg_data[15:0];
                CFG_PERIOD:        period_reg    <= cfg_data[30:0];
                CFG_TOLERANCE:     tol_reg       <= cfg_data[15:0];
                CFG_TIME_MODE:     tmode_reg     <= cfg_data[1:0];
                CFG_TIME_LIMIT:    tlimit_reg    <= cfg_data[31:0];
                CFG_MAX_STEPS:     max_steps_reg <= cfg_data[31:0];
            endcase
        end
    end

    // shared multiplier operands
    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (cmd.mul_sel)
            MS_SX:
            begin
                ma = {n0[15], n0};
                mb = {sx_reg[31], sx_reg};
            end
            MS_SY:
            begin
                ma = {n1[15], n1};
                mb = {sy_reg[31], sy_reg};
            end
            MS_SZ:
            begin
                ma = {n2[15], n2};
                mb = {sz_reg[31], sz_reg};
            end
            MS_EX:
            begin
                ma = {n0[15], n0};
                mb = {ex_reg[31], ex_reg};
            end
            MS_EY:
            begin
                ma = {n1[15], n1};
                mb = {ey_reg[31], ey_reg};
            end
            MS_EZ:
            begin
                ma = {n2[15], n2};
                mb = {ez_reg[31], ez_reg};
            end
            MS_QLO:
            begin
                ma = {1'b0, quo_reg[15:0]};
                mb = dt;
            end
            MS_QHI:
            begin
                ma = {1'b0, quo_reg[31:16]};
                mb = dt;
            end
            MS_TOL:
            begin
                ma = {1'b0, tol_reg};
                mb = {2'b00, period_reg};
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign prod_next = ma * mb;

    // plane distance accumulation
    assign off14    = {{(DW-45){1'b0}}, offset_reg, 14'b0};
    assign prod_ext = {{(DW-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign dot      = acc_reg - d0_reg;

    assign status.cand = d0_reg[DW-1] && !acc_reg[DW-1] && !dot[DW-1] && (dot != '0);

    // shift-subtract step, shared by the interpolation divide and the modulo
    assign div_t    = (cmd.div_op == DIV_STEP_NS) ? rem_reg :
                      {rem_reg[DW-2:0], quo_reg[31]};
    assign div_diff = {1'b0, div_t} - {1'b0, dvs_reg};
    assign div_ge   = !div_diff[DW];

    // interpolated crossing time magnitude
    assign prod_t = {{(TPROD_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign tm     = {{3{t0_reg[31]}}, t0_reg} + tprod_reg[TPROD_W-1:31];
    assign tm_neg = -tm;
    assign abs_tm = tm[34] ? tm_neg[31:0] : tm[31:0];

    // period filter
    assign r16      = {rem_reg[30:0], 16'b0};
    assign tp       = prod_reg[46:0];
    assign per16    = {period_reg, 16'b0};
    assign hi_bound = per16 - tp;
    assign keep     = (r16 < tp) || (hi_bound < r16);

    // termination
    assign cc_new    = cc_reg + {15'b0, (cross_reg && (cc_reg != 16'hFFFF))};
    assign hit_cross = cross_reg && (cc_new >= max_cross_reg);
    assign hit_time  = period_on &&
                       (((tmode_reg == TM_FWD) && (t1_reg >= tlimit_reg)) ||
                        ((tmode_reg == TM_BWD) && (t1_reg <= tlimit_reg)));
    assign hit_steps = period_on && (max_steps_reg != '0) && (sc_reg >= max_steps_reg);
    assign term_next = hit_cross || hit_time || hit_steps;

    always_comb
    begin
        priority if (hit_cross)
            reason_next = RSN_CROSS;
        else if (hit_time)
            reason_next = RSN_TIME;
        else if (hit_steps)
            reason_next = RSN_STEPS;
        else
            reason_next = RSN_NONE;
    end

    // counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg <= '0;
            sc_reg <= '0;
        end
        else if (cmd.out_load)
        begin
            cc_reg <= cc_new;
            sc_reg <= sc_reg + {31'b0, (sc_reg != 32'hFFFF_FFFF)};
        end
    end

    // payload, arithmetic, filter and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            sx_reg <= start_x;
            sy_reg <= start_y;
            sz_reg <= start_z;
            ex_reg <= end_x;
            ey_reg <= end_y;
            ez_reg <= end_z;
            t0_reg <= start_time;
            t1_reg <= end_time;
        end

        if (cmd.mul_en)
            prod_reg <= prod_next;

        unique case (cmd.acc_op)
            ACC_HOLD: acc_reg <= acc_reg;
            ACC_LOAD: acc_reg <= off14;
            ACC_ADD:  acc_reg <= acc_reg + prod_ext;
            ACC_SWAP:
            begin
                d0_reg  <= acc_reg;
                acc_reg <= off14 + prod_ext;
            end
        endcase

        unique case (cmd.div_op)
            DIV_INIT_Q:
            begin
                rem_reg <= '0 - d0_reg;
                dvs_reg <= dot;
                quo_reg <= '0;
            end
            DIV_INIT_M:
            begin
                rem_reg <= '0;
                dvs_reg <= {{(DW-31){1'b0}}, period_reg};
                quo_reg <= abs_tm;
            end
            DIV_STEP_NS, DIV_STEP:
            begin
                rem_reg <= div_ge ? div_diff[DW-1:0] : div_t;
                quo_reg <= {quo_reg[30:0], div_ge};
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase

        unique case (cmd.tp_op)
            TP_LO:   tprod_reg <= prod_t;
            TP_HI:   tprod_reg <= tprod_reg + {prod_t[TPROD_W-17:0], 16'b0};
            default: tprod_reg <= tprod_reg;
        endcase

        if (cmd.cross_load)
            cross_reg <= status.cand;
        else if (cmd.cross_filt)
            cross_reg <= cross_reg && keep;

        if (cmd.out_load)
        begin
            crossed_reg <= cross_reg;
            term_reg    <= term_next;
            reason_reg  <= reason_next;
            total_reg   <= cc_new;
        end
    end

    assign crossed        = crossed_reg;
    assign terminate      = term_reg;
    assign stop_reason    = reason_reg;
    assign crossing_total = total_reg;

endmodule

### rtl/core/pct_ctrl.sv
// ----------------------------------------------------------------------------
// pct_ctrl
// sequencer for one step word: distances, candidate test, interpolation
// divide, time product, modulo, filter and result handoff
// ----------------------------------------------------------------------------
`include "plane_crossing_termination_core_assert.svh"

module pct_ctrl
    import pct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  pct_status_t status,
    output pct_cmd_t    cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = S_TEST;
                    cnt_next   = '0;
                end
            end
            S_TEST:
            begin
                cnt_next = '0;
                if (status.cand && status.period_on)
                    state_next = S_DIV;
                else
                    state_next = S_DONE;
            end
            S_DIV:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_TMUL;
                    cnt_next   = '0;
                end
            end
            S_TMUL:
            begin
                if (cnt_reg == TMUL_LAST)
                begin
                    state_next = S_TIME;
                    cnt_next   = '0;
                end
            end
            S_TIME:
            begin
                state_next = S_MOD;
                cnt_next   = '0;
            end
            S_MOD:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_FILT;
                    cnt_next   = '0;
                end
            end
            S_FILT:
            begin
                state_next = S_DONE;
                cnt_next   = '0;
            end
            S_DONE:
            begin
                cnt_next = '0;
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // output handoff
    always_comb
    begin
        priority if ((state_reg == S_DONE) && out_free)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // datapath commands
    always_comb
    begin
        cmd = '{
            in_load:    1'b0,
            mul_en:     1'b0,
            mul_sel:    MS_SX,
            acc_op:     ACC_HOLD,
            cross_load: 1'b0,
            cross_filt: 1'b0,
            div_op:     DIV_HOLD,
            tp_op:      TP_HOLD,
            out_load:   1'b0
        };
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_load = in_valid;
            end
            S_MUL:
            begin
                cmd.mul_en  = (cnt_reg < MUL_LAST);
                cmd.mul_sel = mul_sel_t'(cnt_reg[3:0]);
                if (cnt_reg == '0)
                    cmd.acc_op = ACC_LOAD;
                else if (cnt_reg == MUL_SWAP)
                    cmd.acc_op = ACC_SWAP;
                else
                    cmd.acc_op = ACC_ADD;
            end
            S_TEST:
            begin
                cmd.cross_load = 1'b1;
                cmd.div_op     = DIV_INIT_Q;
            end
            S_DIV:
            begin
                cmd.div_op = (cnt_reg == '0) ? DIV_STEP_NS : DIV_STEP;
            end
            S_TMUL:
            begin
                cmd.mul_en = 1'b1;
                if (cnt_reg == '0)
                    cmd.mul_sel = MS_QLO;
                else if (cnt_reg == TMUL_LAST)
                begin
                    cmd.mul_sel = MS_TOL;
                    cmd.tp_op   = TP_HI;
                end
                else
                begin
                    cmd.mul_sel = MS_QHI;
                    cmd.tp_op   = TP_LO;
                end
            end
            S_TIME:
            begin
                cmd.div_op = DIV_INIT_M;
            end
            S_MOD:
            begin
                cmd.div_op = DIV_STEP;
            end
            S_FILT:
            begin
                cmd.cross_filt = 1'b1;
            end
            S_DONE:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd.in_load = 1'b0;
            end
        endcase
    end

    `PCT_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, (state_reg == S_MUL) && (cnt_reg == '0), "accepted word did not start the distance sequence")
    `PCT_ASSERT_SAME(a_rise_from_done, $rose(out_valid_reg), $past(state_reg) == S_DONE, "result appeared outside the handoff state")
    `PCT_ASSERT_NEXT(a_done_waits, (state_reg == S_DONE) && out_valid_reg && out_stall, (state_reg == S_DONE) && out_valid_reg, "finished word overwrote a stalled result")
    `PCT_ASSERT_SAME(a_short_count, (state_reg == S_MUL) || (state_reg == S_TMUL), cnt_reg <= MUL_LAST, "multiply sequence count out of range")

endmodule
